>>> hdl/assert_macros.svh
// Assertion helpers shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_AT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Check that a condition implies another one in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, cond, conseq) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error("assertion failed");

`endif

>>> hdl/spa_pkg.sv
`default_nettype none

package spa_pkg;

    localparam int SLOT_COUNT_DEF = 32;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_DONE       = 2'd0,
        ST_EMPTY      = 2'd1,
        ST_NOT_ACTIVE = 2'd2
    } status_t;

    typedef struct packed {
        logic load;
        logic pop;
        logic grant;
        logic release_slot;
        logic reject_empty;
        logic reject_free;
    } dp_cmd_t;

    typedef struct packed {
        logic op_free;
        logic pool_empty;
        logic can_release;
    } dp_stat_t;

endpackage

`default_nettype wire

>>> hdl/spa_datapath.sv
`default_nettype none
`include "assert_macros.svh"

module spa_datapath #(
    parameter int SLOT_COUNT = spa_pkg::SLOT_COUNT_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire spa_pkg::dp_cmd_t cmd,
    output spa_pkg::dp_stat_t     stat,
    input  wire logic [7:0]       s_tdata,  // [4:0] slot_number, [7:5] zero
    input  wire logic             s_tuser,  // [0] func
    output logic [7:0]            m_tdata   // [1:0] status, [6:2] granted_slot, [7] zero
);
    import spa_pkg::*;

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W = $clog2(SLOT_COUNT + 1);

    logic [IDX_W-1:0] stack_mem [SLOT_COUNT];
    logic [IDX_W-1:0] rdata_reg;

    logic             func_reg;
    logic [4:0]       slot_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] lw_reg;
    logic             init_sel_reg;
    logic [IDX_W-1:0] init_val_reg;
    logic [SLOT_COUNT-1:0] active_reg;
    status_t          status_reg;
    logic [4:0]       granted_reg;

    logic [IDX_W-1:0] pop_idx;
    logic [IDX_W-1:0] slot_idx;
    logic [IDX_W-1:0] popped;
    logic             in_range;
    logic             result_load;
    status_t          status_next;
    logic [4:0]       granted_next;

    assign pop_idx  = IDX_W'(count_reg - CNT_W'(1));
    assign slot_idx = IDX_W'(slot_reg);
    assign in_range = 32'(slot_reg) < SLOT_COUNT;
    assign popped   = init_sel_reg ? init_val_reg : rdata_reg;

    assign stat.op_free     = func_reg == FUNC_FREE;
    assign stat.pool_empty  = count_reg == '0;
    assign stat.can_release = in_range && active_reg[slot_idx]
                              && (32'(count_reg) < SLOT_COUNT);

    assign result_load = cmd.grant | cmd.release_slot | cmd.reject_empty | cmd.reject_free;

    always_comb
    begin
        status_next  = ST_DONE;
        granted_next = '0;
        if (cmd.grant)
        begin
            granted_next = 5'(popped);
        end
        else if (cmd.release_slot)
        begin
            granted_next = slot_reg;
        end
        else if (cmd.reject_empty)
        begin
            status_next = ST_EMPTY;
        end
        else
        begin
            status_next = ST_NOT_ACTIVE;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.release_slot)
        begin
            stack_mem[count_reg[IDX_W-1:0]] <= slot_idx;
        end
        if (cmd.pop)
        begin
            rdata_reg <= stack_mem[pop_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg <= s_tuser;
            slot_reg <= s_tdata[4:0];
        end
        if (cmd.pop)
        begin
            init_sel_reg <= CNT_W'(pop_idx) < lw_reg;
            init_val_reg <= IDX_W'(SLOT_COUNT - 1) - pop_idx;
        end
        if (result_load)
        begin
            status_reg  <= status_next;
            granted_reg <= granted_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= CNT_W'(SLOT_COUNT);
            lw_reg     <= CNT_W'(SLOT_COUNT);
            active_reg <= '0;
        end
        else
        begin
            if (cmd.pop)
            begin
                count_reg <= count_reg - CNT_W'(1);
                if (CNT_W'(pop_idx) < lw_reg)
                begin
                    lw_reg <= CNT_W'(pop_idx);
                end
            end
            if (cmd.grant)
            begin
                active_reg[popped] <= 1'b1;
            end
            if (cmd.release_slot)
            begin
                count_reg            <= count_reg + CNT_W'(1);
                active_reg[slot_idx] <= 1'b0;
            end
        end
    end

    assign m_tdata = {1'b0, granted_reg, status_reg};

    `ASSERT_AT(a_count_bound, clk, rst_n, 32'(count_reg) <= SLOT_COUNT)
    `ASSERT_AT(a_lw_below_count, clk, rst_n, lw_reg <= count_reg || cmd.grant == 1'b0)
    `ASSERT_NEXT(a_slot_conserved, clk, rst_n, cmd.load,
        ($countones(active_reg) + int'(count_reg)) == SLOT_COUNT)

endmodule

`default_nettype wire

>>> hdl/spa_ctrl.sv
`default_nettype none
`include "assert_macros.svh"

module spa_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    input  wire spa_pkg::dp_stat_t stat,
    output spa_pkg::dp_cmd_t       cmd
);
    import spa_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_READ
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;
    logic   result_load;

    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (stat.op_free)
                begin
                    if (out_free)
                    begin
                        cmd.release_slot = stat.can_release;
                        cmd.reject_free  = !stat.can_release;
                        state_next       = S_IDLE;
                    end
                end
                else if (stat.pool_empty)
                begin
                    if (out_free)
                    begin
                        cmd.reject_empty = 1'b1;
                        state_next       = S_IDLE;
                    end
                end
                else
                begin
                    cmd.pop    = 1'b1;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                if (out_free)
                begin
                    cmd.grant  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign result_load    = cmd.grant | cmd.release_slot | cmd.reject_empty | cmd.reject_free;
    assign out_valid_next = result_load || (out_valid_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready = state_reg == S_IDLE;
    assign m_tvalid = out_valid_reg;

    `ASSERT_AT(a_one_result, clk, rst_n,
        $onehot0({cmd.grant, cmd.release_slot, cmd.reject_empty, cmd.reject_free}))
    `ASSERT_NEXT(a_pop_then_grant_wait, clk, rst_n, cmd.pop, state_reg == S_READ)
    `ASSERT_AT(a_no_overwrite, clk, rst_n, !(result_load && out_valid_reg && !m_tready))

endmodule

`default_nettype wire

>>> hdl/slot_pool_allocator.sv
// Channel | Dir | tdata                              | tuser
// s_*     | in  | [4:0] slot_number                  | [0] func
// m_*     | out | [1:0] status, [6:2] granted_slot   | none
//
// An item is taken in the idle state; its result loads from the execute state
// for free and for allocate on an empty pool, and from the read state after a
// stack memory read for a granted allocate. The next item can be taken from the
// cycle after the result loads. Reset needs no clearing pass: stack entries never
// written are decoded from a low-water mark of the free count. The result waits
// in an output register; a following item is held, after any pop, until it frees.
`default_nettype none

module slot_pool_allocator #(
    parameter int SLOT_COUNT = spa_pkg::SLOT_COUNT_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,  // [4:0] slot_number, [7:5] zero
    input  wire logic       s_tuser,  // [0] func
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata   // [1:0] status, [6:2] granted_slot, [7] zero
);
    import spa_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    spa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    spa_datapath #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .stat    (stat),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tdata (m_tdata)
    );

endmodule

`default_nettype wire
